// File: hw/rtl/lprq_pkg.sv
// ============================================================================
// Length-prefixed ring queue package
// Shared sizes, codes, job and memory-port types, and the ring pointer adder.
// ============================================================================
`default_nettype none

package lprq_pkg;

   // Ring and record geometry.
   localparam int RING_BYTES   = 1024;
   localparam int HEADER_BYTES = 4;
   localparam int MAX_RECORD   = 64;

   localparam int PTR_W  = $clog2(RING_BYTES);
   localparam int FREE_W = $clog2(RING_BYTES + 1);
   localparam int LEN_W  = 7;
   localparam int STEP_W = $clog2(HEADER_BYTES + (1 << LEN_W));
   localparam int BYTE_W = 8;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [FREE_W-1:0] free_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam ptr_type  MID_PTR   = ptr_type'(RING_BYTES / 2);
   localparam free_type FREE_FULL = free_type'(RING_BYTES);
   localparam step_type HDR_STEP  = step_type'(HEADER_BYTES);
   localparam len_type  MAX_LEN   = len_type'(MAX_RECORD);

   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_PEEK  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BUSY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DATA,
      F_HDR
   } front_state_type;

   // One unit of work for the back end. A count of zero means a single
   // result without a record byte.
   typedef struct packed {
      status_type status;
      len_type    stored_length;
      len_type    count;
      ptr_type    start;
   } job_type;

   typedef struct packed {
      logic    en;
      ptr_type addr;
   } ram_rd_type;

   typedef struct packed {
      logic     en;
      ptr_type  addr;
      byte_type data;
   } ram_wr_type;

   // Advance a ring position, wrapping at the ring end.
   function automatic ptr_type ptr_add(ptr_type p, step_type n);
      logic [PTR_W:0] s;
      s = {1'b0, p} + (PTR_W+1)'(n);
      if (s >= (PTR_W+1)'(RING_BYTES)) begin
         s = s - (PTR_W+1)'(RING_BYTES);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lprq_ring_ram.sv
// ============================================================================
// Ring byte memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module lprq_ring_ram
   import lprq_pkg::*;
(
   input  wire logic       clock,
   input  wire ram_wr_type wr,
   input  wire ram_rd_type rd,
   output      byte_type   rd_data
);

   byte_type ring_mem [RING_BYTES];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_mem[wr.addr] <= wr.data;
      end
   end

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= ring_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lprq_job_fifo.sv
// ============================================================================
// Job queue
// Two-entry queue of jobs from the front end to the back end.
// ============================================================================
`default_nettype none

module lprq_job_fifo
   import lprq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output      job_type pop_job,
   output      logic    full,
   output      logic    empty
);

   job_type    slot_ff [2];
   logic       wr_idx_ff, wr_idx_in;
   logic       rd_idx_ff, rd_idx_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = ~wr_idx_ff;
      end
      if (pop) begin
         rd_idx_in = ~rd_idx_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= push_job;
      end
   end

   assign pop_job = slot_ff[rd_idx_ff];
   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("job queue written while full");

endmodule

`default_nettype wire

// File: hw/rtl/lprq_front.sv
// ============================================================================
// Front end
// Takes transactions, keeps the ring pointers and free space, writes pushed
// bytes, reads record headers and queues one job per transaction.
// ============================================================================
`default_nettype none

module lprq_front
   import lprq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire mode_type   req_mode,
   input  wire byte_type   req_byte,
   input  wire len_type    req_rec_len,
   input  wire len_type    req_max,
   input  wire logic       job_full,
   output      logic       job_push,
   output      job_type    job,
   input  wire logic       stream_done,
   output      ram_wr_type ram_wr,
   output      ram_rd_type ram_rd,
   input  wire byte_type   ram_rd_data
);

   front_state_type state_ff, state_in;
   ptr_type         rp_ff, rp_in;
   ptr_type         wp_ff, wp_in;
   free_type        free_ff, free_in;
   len_type         left_ff, left_in;
   logic            drop_ff, drop_in;
   logic            pend_ff, pend_in;
   logic            is_pop_ff, is_pop_in;
   len_type         max_ff, max_in;
   byte_type        byte_ff, byte_in;

   logic     accept;
   free_type need;
   len_type  hdr_len;
   len_type  hdr_min;
   len_type  hdr_cnt;
   step_type total;
   free_type used;
   free_type free_grow;

   assign req_ready = (state_ff == F_IDLE) && !job_full && !pend_ff;
   assign accept    = req_valid && req_ready;
   assign need      = free_type'(HEADER_BYTES) + free_type'(req_rec_len);

   // Stored lengths never exceed the record limit. Only the low header byte is
   // written, and the length is taken from that byte.
   assign hdr_len   = ram_rd_data[LEN_W-1:0];
   assign hdr_min   = (hdr_len < max_ff) ? hdr_len : max_ff;
   assign hdr_cnt   = (hdr_min > MAX_LEN) ? MAX_LEN : hdr_min;
   assign total     = HDR_STEP + step_type'(hdr_len);
   assign used      = FREE_FULL - free_ff;
   assign free_grow = free_ff + free_type'(total);

   always_comb begin
      state_in  = state_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      free_in   = free_ff;
      left_in   = left_ff;
      drop_in   = drop_ff;
      pend_in   = pend_ff;
      is_pop_in = is_pop_ff;
      max_in    = max_ff;
      byte_in   = byte_ff;
      job_push  = 1'b0;
      job       = '0;
      ram_wr    = '0;
      ram_rd    = '0;
      if (stream_done) begin
         pend_in = 1'b0;
      end
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_PUSH: begin
                     job_push   = 1'b1;
                     job.status = ST_OK;
                     if (left_ff != '0) begin
                        left_in = left_ff - len_type'(1);
                        if (drop_ff) begin
                           job.status = ST_FULL;
                           if (left_ff == len_type'(1)) begin
                              drop_in = 1'b0;
                           end
                        end else begin
                           ram_wr  = '{en: 1'b1, addr: wp_ff, data: req_byte};
                           wp_in   = ptr_add(wp_ff, step_type'(1));
                        end
                     end else if (req_rec_len > MAX_LEN || free_ff < need) begin
                        // Rejected record: its remaining bytes are skipped.
                        job.status = ST_FULL;
                        left_in    = (req_rec_len != '0) ? req_rec_len - len_type'(1) : '0;
                        drop_in    = (req_rec_len > len_type'(1));
                     end else begin
                        free_in = free_ff - need;
                        ram_wr  = '{en: 1'b1, addr: wp_ff, data: byte_type'(req_rec_len)};
                        wp_in   = ptr_add(wp_ff, HDR_STEP);
                        if (req_rec_len != '0) begin
                           byte_in  = req_byte;
                           left_in  = req_rec_len - len_type'(1);
                           state_in = F_DATA;
                        end
                     end
                  end
                  MODE_CLEAR: begin
                     job_push   = 1'b1;
                     job.status = ST_OK;
                     rp_in      = MID_PTR;
                     wp_in      = MID_PTR;
                     free_in    = FREE_FULL;
                     left_in    = '0;
                     drop_in    = 1'b0;
                  end
                  MODE_POP, MODE_PEEK: begin
                     if (left_ff != '0) begin
                        job_push   = 1'b1;
                        job.status = ST_BUSY;
                     end else if (free_ff >= FREE_FULL) begin
                        job_push   = 1'b1;
                        job.status = ST_EMPTY;
                     end else begin
                        ram_rd    = '{en: 1'b1, addr: rp_ff};
                        is_pop_in = (req_mode == MODE_POP);
                        max_in    = req_max;
                        state_in  = F_HDR;
                     end
                  end
                  default: begin
                     job_push = 1'b0;
                  end
               endcase
            end
         end
         F_DATA: begin
            // First data byte of a record, after its header.
            ram_wr   = '{en: 1'b1, addr: wp_ff, data: byte_ff};
            wp_in    = ptr_add(wp_ff, step_type'(1));
            state_in = F_IDLE;
         end
         F_HDR: begin
            if (!job_full) begin
               job_push          = 1'b1;
               job.status        = ST_OK;
               job.stored_length = hdr_len;
               job.count         = hdr_cnt;
               job.start         = ptr_add(rp_ff, HDR_STEP);
               if (hdr_cnt != '0) begin
                  pend_in = 1'b1;
               end
               if (is_pop_ff) begin
                  rp_in   = ptr_add(rp_ff, total);
                  free_in = (free_type'(total) >= used) ? FREE_FULL : free_grow;
               end
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         rp_ff    <= MID_PTR;
         wp_ff    <= MID_PTR;
         free_ff  <= FREE_FULL;
         left_ff  <= '0;
         drop_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         free_ff  <= free_in;
         left_ff  <= left_in;
         drop_ff  <= drop_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      is_pop_ff <= is_pop_in;
      max_ff    <= max_in;
      byte_ff   <= byte_in;
   end

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_FULL)
      else $error("free space above ring size");

   a_drop_left: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> left_ff != '0)
      else $error("skipping a record with no bytes left");

endmodule

`default_nettype wire

// File: hw/rtl/lprq_back.sv
// ============================================================================
// Back end
// Turns queued jobs into result transactions, streaming record bytes from
// the ring through a read stage and an output register.
// ============================================================================
`default_nettype none

module lprq_back
   import lprq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       job_valid,
   input  wire job_type    job,
   output      logic       job_pop,
   output      ram_rd_type ram_rd,
   input  wire byte_type   ram_rd_data,
   output      logic       stream_done,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      status_type rsp_status,
   output      byte_type   rsp_byte,
   output      logic       rsp_byte_valid,
   output      len_type    rsp_len,
   output      logic       rsp_last
);

   ptr_type    addr_ff, addr_in;
   len_type    left_ff, left_in;
   len_type    len_ff, len_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_last_ff, s1_last_in;
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   byte_type   out_byte_ff, out_byte_in;
   logic       out_bv_ff, out_bv_in;
   len_type    out_len_ff, out_len_in;
   logic       out_last_ff, out_last_in;

   logic out_free;
   logic move;
   logic issue;
   logic idle;
   logic take;

   assign out_free = !out_valid_ff || rsp_ready;
   assign move     = s1_valid_ff && out_free;
   assign issue    = (left_ff != '0) && (!s1_valid_ff || move);
   assign idle     = (left_ff == '0) && !s1_valid_ff;
   assign take     = idle && job_valid && ((job.count != '0) || out_free);

   assign job_pop     = take;
   assign ram_rd      = '{en: issue, addr: addr_ff};
   // The ring is released once the final byte has left the read register.
   assign stream_done = move && s1_last_ff;

   always_comb begin
      addr_in       = addr_ff;
      left_in       = left_ff;
      len_in        = len_ff;
      s1_valid_in   = s1_valid_ff;
      s1_last_in    = s1_last_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_bv_in     = out_bv_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;

      if (issue) begin
         addr_in     = ptr_add(addr_ff, step_type'(1));
         left_in     = left_ff - len_type'(1);
         s1_valid_in = 1'b1;
         s1_last_in  = (left_ff == len_type'(1));
      end else if (move) begin
         s1_valid_in = 1'b0;
      end

      if (take && job.count != '0) begin
         addr_in = job.start;
         left_in = job.count;
         len_in  = job.stored_length;
      end

      if (move) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_OK;
         out_byte_in   = ram_rd_data;
         out_bv_in     = 1'b1;
         out_len_in    = len_ff;
         out_last_in   = s1_last_ff;
      end else if (take && job.count == '0) begin
         out_valid_in  = 1'b1;
         out_status_in = job.status;
         out_byte_in   = '0;
         out_bv_in     = 1'b0;
         out_len_in    = job.stored_length;
         out_last_in   = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      s1_last_ff    <= s1_last_in;
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_bv_ff     <= out_bv_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_byte       = out_byte_ff;
   assign rsp_byte_valid = out_bv_ff;
   assign rsp_len        = out_len_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/length_prefixed_ring_queue_core.sv
// ============================================================================
// Length-prefixed ring queue core
// Byte ring holding variable-length records behind a length header, with
// push, pop, peek and clear commands arriving on one request stream.
// ============================================================================
//
//  Channel  Direction  Handshake               Payload
//  req      in         req_tvalid/req_tready   tuser mode, tdata byte/len/max
//  rsp      out        rsp_tvalid/rsp_tready   tuser status/valid, tdata, tlast
//
// A push transaction is taken in the idle state, but the first byte of an
// accepted record is written by F_DATA after the header, as the two share
// the single write port of the ring memory. A pop or peek fetches the header
// through F_HDR, then streams one record byte per cycle from the ring read
// port while the result side accepts. Reset is synchronous; the pointers go
// to mid ring and the ring contents need no clearing pass, as only fully
// written records are ever read. A stall on the result side backs up
// through the output register and the job queue. Besides the F_DATA and
// F_HDR states, the request side stops while the queue is full or a record
// stream is still reading the ring.
`default_nettype none

module length_prefixed_ring_queue_core
   import lprq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] push_byte, [14:8] record_length, [21:15] max_bytes, [23:22] zero
   input  wire logic [23:0] req_tdata,
   // [1:0] mode
   input  wire logic [1:0]  req_tuser,

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte, [14:8] stored_length, [15] zero
   output      logic [15:0] rsp_tdata,
   // [1:0] status, [2] byte_valid
   output      logic [2:0]  rsp_tuser,
   output      logic        rsp_tlast
);

   // Jobs travel from the front end to the back end through a short queue.
   logic    job_push;
   job_type job_in;
   logic    job_pop;
   job_type job_out;
   logic    job_full;
   logic    job_empty;
   logic    stream_done;

   // The ring read port is shared: the front end reads headers and the back
   // end reads record bytes, never in the same cycle.
   ram_wr_type ram_wr;
   ram_rd_type front_rd;
   ram_rd_type back_rd;
   ram_rd_type ram_rd;
   byte_type   ram_rd_data;

   status_type rsp_status;
   byte_type   rsp_byte;
   logic       rsp_byte_valid;
   len_type    rsp_len;

   lprq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (mode_type'(req_tuser)),
      .req_byte    (req_tdata[7:0]),
      .req_rec_len (req_tdata[14:8]),
      .req_max     (req_tdata[21:15]),
      .job_full    (job_full),
      .job_push    (job_push),
      .job         (job_in),
      .stream_done (stream_done),
      .ram_wr      (ram_wr),
      .ram_rd      (front_rd),
      .ram_rd_data (ram_rd_data)
   );

   lprq_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .pop_job  (job_out),
      .full     (job_full),
      .empty    (job_empty)
   );

   lprq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (!job_empty),
      .job            (job_out),
      .job_pop        (job_pop),
      .ram_rd         (back_rd),
      .ram_rd_data    (ram_rd_data),
      .stream_done    (stream_done),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_byte       (rsp_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_len        (rsp_len),
      .rsp_last       (rsp_tlast)
   );

   assign ram_rd = back_rd.en ? back_rd : front_rd;

   lprq_ring_ram u_ring_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {1'b0, rsp_len, rsp_byte};
   assign rsp_tuser = {rsp_byte_valid, rsp_status};

   // Header reads and record byte reads must never collide on the ring port.
   a_rd_port_shared: assert property (@(posedge clock) disable iff (reset)
      !(front_rd.en && back_rd.en))
      else $error("front and back read the ring in the same cycle");

endmodule

`default_nettype wire
